### design/lzss_pkg.sv
// Shared types and constants of the LZSS bit-stream decoder.
package lzss_pkg;

    // Window geometry.
    localparam int WIN_DEPTH = 4096;
    localparam int WIN_AW    = 12;
    localparam int FILL_W    = WIN_AW + 1;

    // Field and counter widths.
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 24;
    localparam int TOK_W     = 16;
    localparam int TOKCNT_W  = 5;
    localparam int LEN_W     = 4;
    localparam int IDX_W     = 5;

    // Token lengths in bits.
    localparam logic [TOKCNT_W-1:0] LIT_BITS = 5'd9;
    localparam logic [TOKCNT_W-1:0] REF_BITS = 5'd17;

    // Register value after reset.
    localparam logic [CNT_W-1:0] TOTAL_RESET = 24'hFFFFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input transaction
        logic restart;   // start a new stream
        logic bit_step;  // shift one bit into the token
        logic rd;        // issue a window read for the copy
        logic emit;      // deliver one data byte
        logic src_lit;   // data byte comes from the literal
        logic emit_end;  // deliver the bare end notice
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tok_lit;   // this bit completes a literal
        logic tok_ref;   // this bit completes a back-reference
        logic tok_end;   // this bit completes the end marker
        logic slot_free; // the output register can take a result
        logic hit;       // the next byte reaches the output count
        logic copy_last; // the current copy byte is the final one
        logic finished;  // the stream has ended
    } t_status;

endpackage

### design/lzss_bitstream_decoder_top.sv
// LZSS bit-stream decoder with a 4096-byte window.
// Each input byte is consumed one bit per cycle between deliveries; a literal adds a step to
// deliver and a back-reference adds a window read, then an emit, per copied byte.
// The output register lets a result wait while decoding carries on to the next result.
// Reset is synchronous, active low: window empty, write index 1, count register all ones.
module lzss_bitstream_decoder_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [lzss_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                        i_first,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lzss_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_byte_valid,
    output logic                        o_last,
    output logic                        o_done_res,
    input  logic                        i_cfg_we,
    input  logic [lzss_pkg::CNT_W-1:0]  i_cfg_data
);

    lzss_pkg::t_cmd    cmd;
    lzss_pkg::t_status status;

    // Sequencer.
    lzss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_first    (i_first),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Token, window and output path.
    lzss_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_byte    (i_in_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_done_res   (o_done_res),
        .i_cmd        (cmd),
        .o_status     (status)
    );

endmodule

### design/lzss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/lzss_ctrl.sv
// Controller state machine of the LZSS decoder: bit sequencing and copy steps.
module lzss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_first,
    output logic             o_in_ready,
    input  lzss_pkg::t_status i_status,
    output lzss_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_BIT      = 3'd1;
    localparam logic [2:0] ST_RD       = 3'd2;
    localparam logic [2:0] ST_EMIT_LIT = 3'd3;
    localparam logic [2:0] ST_EMIT_REF = 3'd4;
    localparam logic [2:0] ST_END      = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [3:0] r_bits;
    logic [3:0] n_bits;
    logic       accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Next state, bit counter and commands.
    always_comb begin
        n_state = r_state;
        n_bits  = r_bits;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.restart = i_first;
                    n_bits        = 4'd8;
                    if (i_first || !i_status.finished) begin
                        n_state = ST_BIT;
                    end
                end
            end
            ST_BIT: begin
                o_cmd.bit_step = 1'b1;
                n_bits         = r_bits - 4'd1;
                if (i_status.tok_lit) begin
                    n_state = ST_EMIT_LIT;
                end else if (i_status.tok_ref) begin
                    n_state = ST_RD;
                end else if (i_status.tok_end) begin
                    n_state = ST_END;
                end else if (r_bits == 4'd1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_EMIT_REF;
            end
            ST_EMIT_LIT, ST_EMIT_REF: begin
                o_cmd.src_lit = (r_state == ST_EMIT_LIT);
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.hit) begin
                        n_state = ST_IDLE;
                    end else if (r_state == ST_EMIT_LIT || i_status.copy_last) begin
                        n_state = (r_bits == 4'd0) ? ST_IDLE : ST_BIT;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_END: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_end = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bits  <= 4'd0;
        end else begin
            r_state <= n_state;
            r_bits  <= n_bits;
        end
    end

endmodule

### design/lzss_datapath.sv
// Datapath of the LZSS decoder: token assembly, window, counters and output register.
module lzss_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lzss_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_cfg_we,
    input  logic [lzss_pkg::CNT_W-1:0]    i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [lzss_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_byte_valid,
    output logic                          o_last,
    output logic                          o_done_res,
    input  lzss_pkg::t_cmd                i_cmd,
    output lzss_pkg::t_status             o_status
);

    // Stream state.
    logic [lzss_pkg::BYTE_W-1:0]   r_byte;
    logic [lzss_pkg::TOK_W-1:0]    r_tok;
    logic [lzss_pkg::TOKCNT_W-1:0] r_tok_cnt;
    logic [lzss_pkg::BYTE_W-1:0]   r_lit;
    logic [lzss_pkg::WIN_AW-1:0]   r_off;
    logic [lzss_pkg::LEN_W-1:0]    r_len;
    logic [lzss_pkg::IDX_W-1:0]    r_idx;
    logic                          r_rd_ok;
    logic [lzss_pkg::WIN_AW-1:0]   r_wr_idx;
    logic [lzss_pkg::FILL_W-1:0]   r_fill;
    logic [lzss_pkg::CNT_W-1:0]    r_out_count;
    logic                          r_finished;
    logic [lzss_pkg::CNT_W-1:0]    r_total;

    // Output register.
    logic                          r_out_valid;
    logic [lzss_pkg::BYTE_W-1:0]   r_out_byte;
    logic                          r_byte_valid;
    logic                          r_last;
    logic                          r_done_res;

    logic [lzss_pkg::TOK_W-1:0]    n_tok;
    logic [lzss_pkg::TOKCNT_W-1:0] n_tok_cnt;
    logic [lzss_pkg::WIN_AW-1:0]   n_off;
    logic                          is_lit;
    logic                          is_full;
    logic [lzss_pkg::WIN_AW-1:0]   rd_addr;
    logic [lzss_pkg::WIN_AW-1:0]   rd_prev;
    logic [lzss_pkg::BYTE_W-1:0]   ram_q;
    logic [lzss_pkg::BYTE_W-1:0]   emit_data;
    logic [lzss_pkg::CNT_W-1:0]    n_out_count;
    logic                          hit;
    logic                          copy_last;
    logic                          slot_free;
    logic                          win_we;

    // Token after shifting in the current bit.
    assign n_tok     = {r_tok[lzss_pkg::TOK_W-2:0], r_byte[lzss_pkg::BYTE_W-1]};
    assign n_tok_cnt = r_tok_cnt + 5'd1;
    assign n_off     = n_tok[lzss_pkg::TOK_W-1:lzss_pkg::LEN_W];
    assign is_lit    = (n_tok_cnt == lzss_pkg::LIT_BITS) && n_tok[lzss_pkg::BYTE_W];
    assign is_full   = (n_tok_cnt == lzss_pkg::REF_BITS);

    // Window read address; entries beyond the fill count read as zero.
    assign rd_addr   = r_off + {{(lzss_pkg::WIN_AW-lzss_pkg::IDX_W){1'b0}}, r_idx};
    assign rd_prev   = rd_addr - 12'd1;

    // Emitted byte and output count check.
    assign emit_data   = i_cmd.src_lit ? r_lit : (r_rd_ok ? ram_q : 8'd0);
    assign n_out_count = r_out_count + 24'd1;
    assign hit         = (n_out_count == r_total);
    assign copy_last   = (r_idx == ({1'b0, r_len} + 5'd1));
    assign slot_free   = !r_out_valid || i_out_ready;
    assign win_we      = i_cmd.emit && !hit;

    lzss_ram #(
        .WIDTH (lzss_pkg::BYTE_W),
        .DEPTH (lzss_pkg::WIN_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (r_wr_idx),
        .i_wdata (emit_data),
        .i_re    (i_cmd.rd),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Stream control state: token, counters, fill level and finish flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_tok       <= '0;
            r_tok_cnt   <= '0;
            r_wr_idx    <= 12'd1;
            r_fill      <= '0;
            r_out_count <= '0;
            r_finished  <= 1'b0;
        end else begin
            if (i_cmd.bit_step) begin
                if (is_lit || is_full) begin
                    r_tok     <= '0;
                    r_tok_cnt <= '0;
                end else begin
                    r_tok     <= n_tok;
                    r_tok_cnt <= n_tok_cnt;
                end
                if (is_full && n_off == '0) begin
                    r_finished <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_count <= n_out_count;
                if (hit) begin
                    r_finished <= 1'b1;
                end else begin
                    r_wr_idx <= r_wr_idx + 12'd1;
                    if (r_fill != lzss_pkg::FILL_W'(lzss_pkg::WIN_DEPTH)) begin
                        r_fill <= r_fill + 13'd1;
                    end
                end
            end
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= lzss_pkg::TOTAL_RESET;
        end else if (i_cfg_we) begin
            r_total <= i_cfg_data;
        end
    end

    // Input byte shifter, literal and back-reference fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_in_byte;
        end else if (i_cmd.bit_step) begin
            r_byte <= {r_byte[lzss_pkg::BYTE_W-2:0], 1'b0};
        end
        if (i_cmd.bit_step && is_lit) begin
            r_lit <= n_tok[lzss_pkg::BYTE_W-1:0];
        end
        if (i_cmd.bit_step && is_full) begin
            r_off <= n_off;
            r_len <= n_tok[lzss_pkg::LEN_W-1:0];
            r_idx <= '0;
        end else if (i_cmd.emit && !i_cmd.src_lit) begin
            r_idx <= r_idx + 5'd1;
        end
        if (i_cmd.rd) begin
            r_rd_ok <= ({1'b0, rd_prev} < r_fill);
        end
    end

    // Output register: loaded by a result, cleared when its transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte   <= emit_data;
            r_byte_valid <= 1'b1;
            r_last       <= hit || i_cmd.src_lit || copy_last;
            r_done_res   <= hit;
        end else if (i_cmd.emit_end) begin
            r_out_byte   <= '0;
            r_byte_valid <= 1'b0;
            r_last       <= 1'b1;
            r_done_res   <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_last       = r_last;
    assign o_done_res   = r_done_res;

    // Status towards the controller.
    always_comb begin
        o_status           = '0;
        o_status.tok_lit   = is_lit;
        o_status.tok_ref   = is_full && (n_off != '0);
        o_status.tok_end   = is_full && (n_off == '0);
        o_status.slot_free = slot_free;
        o_status.hit       = hit;
        o_status.copy_last = copy_last;
        o_status.finished  = r_finished;
    end

endmodule

### tb/sv/lzss_bitstream_decoder_top_tb.sv
// Self-checking testbench for the LZSS bit-stream decoder: coded streams in, predicted bytes out.
`timescale 1ns / 1ps

module lzss_bitstream_decoder_top_tb;

    // Constants taken from the shared package.
    localparam int BYTE_W    = lzss_pkg::BYTE_W;
    localparam int WIN_DEPTH = lzss_pkg::WIN_DEPTH;
    localparam int WIN_AW    = lzss_pkg::WIN_AW;
    localparam int CNT_W     = lzss_pkg::CNT_W;
    localparam int LEN_W     = lzss_pkg::LEN_W;
    localparam int TOKCNT_W  = lzss_pkg::TOKCNT_W;
    localparam logic [TOKCNT_W-1:0] LIT_BITS    = lzss_pkg::LIT_BITS;
    localparam logic [TOKCNT_W-1:0] REF_BITS    = lzss_pkg::REF_BITS;
    localparam logic [CNT_W-1:0]    TOTAL_RESET = lzss_pkg::TOTAL_RESET;

    localparam int SETTLE_CYCLES = 64;     // idle wait after the last expected result
    localparam int STALL_LIMIT   = 20000;  // cycles without any transaction before giving up
    localparam int LONG_HOLD     = 400;    // receiver back-pressure stretch
    localparam int RANDOM_ITEMS  = 220;

    // One decoded result as seen on the output channel.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              byte_valid;
        logic              last;
        logic              done;
    } t_decoded;

    // One coded byte as offered on the input channel.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
    } t_coded;

    // Decoder predictor and the store of decoded bytes still to arrive.
    class lzss_scoreboard;
        logic [BYTE_W-1:0]   window [WIN_DEPTH];
        logic [WIN_AW-1:0]   wr_idx;
        logic [16:0]         token;
        logic [TOKCNT_W-1:0] token_cnt;
        logic [CNT_W-1:0]    out_cnt;
        logic [CNT_W-1:0]    total;
        bit                  finished;
        t_decoded            step_q[$];
        t_decoded            expected_q[$];
        int                  errors;

        function new();
            total  = TOTAL_RESET;
            errors = 0;
            restart();
        endfunction

        // A new stream empties the window and the token; the count limit is kept.
        function void restart();
            foreach (window[idx]) window[idx] = '0;
            wr_idx    = WIN_AW'(1);
            token     = '0;
            token_cnt = '0;
            out_cnt   = '0;
            finished  = 1'b0;
        endfunction

        function void set_total(logic [CNT_W-1:0] value);
            total = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Delivers one data byte; returns 1 when it reaches the output count.
        function bit emit_data(logic [BYTE_W-1:0] value);
            t_decoded r;
            out_cnt      = out_cnt + 1'b1;
            r.data       = value;
            r.byte_valid = 1'b1;
            r.last       = 1'b0;
            r.done       = (out_cnt == total);
            step_q.push_back(r);
            if (r.done) begin
                finished = 1'b1;
                return 1'b1;
            end
            window[wr_idx] = value;
            wr_idx         = wr_idx + 1'b1;
            return 1'b0;
        endfunction

        // Decodes one accepted input transaction into its expected results.
        function void note_input(logic [BYTE_W-1:0] b, logic first);
            logic [WIN_AW-1:0] offset;
            logic [LEN_W-1:0]  length;
            logic [BYTE_W-1:0] lit;
            t_decoded          r;
            if (first)
                restart();
            if (finished)
                return;
            step_q.delete();
            for (int k = BYTE_W - 1; k >= 0 && !finished; k--) begin
                token     = {token[15:0], b[k]};
                token_cnt = token_cnt + 1'b1;
                if (token_cnt == LIT_BITS && token[8]) begin
                    lit       = token[7:0];
                    token     = '0;
                    token_cnt = '0;
                    void'(emit_data(lit));
                end else if (token_cnt >= REF_BITS) begin
                    offset    = token[15:4];
                    length    = token[3:0];
                    token     = '0;
                    token_cnt = '0;
                    if (offset == '0) begin
                        // End marker: a bare notice with no data.
                        finished     = 1'b1;
                        r.data       = '0;
                        r.byte_valid = 1'b0;
                        r.last       = 1'b0;
                        r.done       = 1'b1;
                        step_q.push_back(r);
                    end else begin
                        for (int i = 0; i < length + 2; i++) begin
                            if (emit_data(window[offset + i[WIN_AW-1:0]]))
                                break;
                        end
                    end
                end
            end
            if (step_q.size() > 0) begin
                r      = step_q.pop_back();
                r.last = 1'b1;
                step_q.push_back(r);
            end
            foreach (step_q[j])
                expected_q.push_back(step_q[j]);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("ERROR: %s", msg);
        endtask

        // Compares one accepted result with the oldest expectation.
        task check_result(logic [BYTE_W-1:0] data, logic byte_valid, logic last, logic done);
            t_decoded want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf(
                    "unexpected result: byte %02h valid %0b last %0b done %0b",
                    data, byte_valid, last, done));
                return;
            end
            want = expected_q.pop_front();
            if (data !== want.data || byte_valid !== want.byte_valid ||
                last !== want.last || done !== want.done)
                report_mismatch($sformatf({"result mismatch: byte %02h/%02h valid %0b/%0b ",
                                           "last %0b/%0b done %0b/%0b (got/expected)"},
                                          data, want.data, byte_valid, want.byte_valid,
                                          last, want.last, done, want.done));
        endtask
    endclass

    // Clock, reset and block inputs, all known from time zero.
    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              in_valid = 1'b0;
    logic [BYTE_W-1:0] in_byte  = '0;
    logic              in_first = 1'b0;
    logic              out_ready = 1'b0;
    logic              cfg_we   = 1'b0;
    logic [CNT_W-1:0]  cfg_data = '0;

    logic              o_in_ready;
    logic              o_out_valid;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_byte_valid;
    logic              o_last;
    logic              o_done_res;

    lzss_scoreboard    sb;
    int                send_pct;
    int                recv_pct;
    bit                hold_req = 1'b0;

    // Stimulus under construction: bits of the current stream, then packed bytes.
    bit                stream_bits_q[$];
    t_coded            stim_q[$];
    logic [WIN_AW-1:0] gen_pos;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    lzss_bitstream_decoder_top dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (in_byte),
        .i_first      (in_first),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_done_res   (o_done_res),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data)
    );

    // Stream building: tokens are appended most significant bit first.
    function automatic void put_bits(int unsigned value, int width);
        for (int j = width - 1; j >= 0; j--)
            stream_bits_q.push_back(value[j]);
    endfunction

    function automatic void add_literal(logic [BYTE_W-1:0] value);
        put_bits(1, 1);
        put_bits(32'(value), BYTE_W);
        gen_pos = gen_pos + 1'b1;
    endfunction

    function automatic void add_copy(logic [WIN_AW-1:0] offset, logic [LEN_W-1:0] length);
        put_bits(0, 1);
        put_bits(32'(offset), WIN_AW);
        put_bits(32'(length), LEN_W);
        gen_pos = gen_pos + length + 2'd2;
    endfunction

    function automatic void add_end(logic [LEN_W-1:0] length);
        put_bits(0, 1);
        put_bits(0, WIN_AW);
        put_bits(32'(length), LEN_W);
    endfunction

    // Pads the stream to whole bytes with random bits and queues the bytes.
    function automatic void pack_stream(bit mark);
        t_coded item;
        bit     is_first;
        is_first = 1'b1;
        while (stream_bits_q.size() % BYTE_W != 0)
            stream_bits_q.push_back(1'($urandom_range(1)));
        while (stream_bits_q.size() > 0) begin
            for (int j = 0; j < BYTE_W; j++)
                item.data = {item.data[BYTE_W-2:0], stream_bits_q.pop_front()};
            item.first = mark & is_first;
            is_first   = 1'b0;
            stim_q.push_back(item);
        end
    endfunction

    // Mostly well-formed streams with random content, some noise and unmarked streams.
    function automatic void gen_random_stream();
        int                pick;
        int                n_tok;
        logic [WIN_AW-1:0] offset;
        logic [WIN_AW-1:0] back_dist;
        t_coded            item;
        pick = $urandom_range(99);
        if (pick < 10) begin
            repeat ($urandom_range(1, 3)) begin
                item.data  = BYTE_W'($urandom_range(255));
                item.first = 1'($urandom_range(1));
                stim_q.push_back(item);
            end
            return;
        end
        gen_pos = WIN_AW'(1);
        n_tok   = $urandom_range(1, 10);
        repeat (n_tok) begin
            if ($urandom_range(99) < 45) begin
                add_literal(BYTE_W'($urandom_range(255)));
            end else begin
                if ($urandom_range(1)) begin
                    offset = WIN_AW'($urandom_range(1, WIN_DEPTH - 1));
                end else begin
                    // Short distance back, often overlapping the bytes being written.
                    back_dist = WIN_AW'($urandom_range(1, 24));
                    offset    = gen_pos - back_dist;
                    if (offset == '0)
                        offset = WIN_AW'(1);
                end
                add_copy(offset, LEN_W'($urandom_range(15)));
            end
        end
        if ($urandom_range(99) < 60)
            add_end(LEN_W'($urandom_range(15)));
        pack_stream(pick >= 20);
        if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(1, 2)) begin
                item.data  = BYTE_W'($urandom_range(255));
                item.first = 1'b0;
                stim_q.push_back(item);
            end
        end
    endfunction

    // Offers one input transaction and returns at the edge that accepts it.
    task automatic send_item(t_coded item);
        while ($urandom_range(99) < send_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= item.data;
        in_first <= item.first;
        @(posedge clk);
        while (!o_in_ready)
            @(posedge clk);
        sb.note_input(item.data, item.first);
    endtask

    task automatic send_all();
        t_coded item;
        while (stim_q.size() > 0) begin
            item = stim_q.pop_front();
            send_item(item);
        end
    endtask

    // Stops offering, waits for every expected result, then lets the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_total(logic [CNT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.set_total(value);
    endtask

    // Receiver: checks accepted results and applies random or long back-pressure.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (o_out_valid && out_ready)
                sb.check_result(o_out_byte, o_byte_valid, o_last, o_done_res);
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_pct);
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("lzss_bitstream_decoder_top verification failed");
        $finish;
    end

    initial begin : stimulus
        int sent;
        sb       = new();
        send_pct = 18;
        recv_pct = 52;
        gen_pos  = WIN_AW'(1);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Decoding straight from the reset state: byte extremes, a copy reaching
        // round the window edge, an overlapping run, and the end marker.
        add_literal(8'h00);
        add_literal(8'hFF);
        add_copy(12'd1, 4'd0);
        add_copy(12'hFFF, 4'hF);
        add_literal(8'hA5);
        add_copy(12'd22, 4'hF);
        add_end(4'hF);
        pack_stream(1'b0);
        stim_q.push_back('{8'hFF, 1'b0});
        send_all();
        drain();

        // Output count reached in the middle of a copy; later bytes are ignored.
        write_total(24'd5);
        add_literal(8'h5A);
        add_literal(8'h3C);
        add_copy(12'd1, 4'hF);
        pack_stream(1'b1);
        stim_q.push_back('{8'h00, 1'b0});
        send_all();
        drain();

        // Smallest count: the first literal finishes the stream.
        write_total(24'd1);
        add_literal(8'h81);
        pack_stream(1'b1);
        send_all();
        drain();

        // Random streams under three idling patterns and count limits.
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_pct = 18;
                    recv_pct = 52;
                    write_total(TOTAL_RESET);
                end
                1: begin
                    send_pct = 52;
                    recv_pct = 18;
                    write_total(CNT_W'($urandom_range(10, 60)));
                end
                default: begin
                    send_pct = 0;
                    recv_pct = 0;
                    write_total(CNT_W'($urandom_range(30, 120)));
                    hold_req = 1'b1;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / 3) begin
                gen_random_stream();
                sent += stim_q.size();
                send_all();
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("lzss_bitstream_decoder_top verification clean");
        else
            $display("lzss_bitstream_decoder_top verification failed");
        $finish;
    end

endmodule

### filelist.f
design/lzss_pkg.sv
design/lzss_ram.sv
design/lzss_ctrl.sv
design/lzss_datapath.sv
design/lzss_bitstream_decoder_top.sv
tb/sv/lzss_bitstream_decoder_top_tb.sv
